// ===== sv/gprb_pkg.sv =====
// gprb_pkg: shared types, register offsets and helpers for the gpio port register block
// no dependencies; imported by gpio_port_register_block_top
`default_nettype none

package gprb_pkg;

  // size of the whole port region in bytes
  localparam int REGION_SIZE = 512;

  // byte offsets inside one group
  localparam int OFF_DIR    = 'h00;
  localparam int OFF_DIRCLR = 'h04;
  localparam int OFF_DIRSET = 'h08;
  localparam int OFF_DIRTGL = 'h0C;
  localparam int OFF_OUT    = 'h10;
  localparam int OFF_OUTCLR = 'h14;
  localparam int OFF_OUTSET = 'h18;
  localparam int OFF_OUTTGL = 'h1C;
  localparam int OFF_IN     = 'h20;

  // control states
  typedef enum logic {
    ST_IDLE,
    ST_RMW
  } state_t;

  // which word of a group an access addresses
  typedef enum logic [1:0] {
    KIND_DIR  = 2'd0,
    KIND_OUT  = 2'd1,
    KIND_IN   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // write operation on the addressed word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_REPL,
    OP_CLR,
    OP_SET,
    OP_TGL
  } op_t;

  // byte mask for an access of 1 to 4 bytes
  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    unique case (size)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // apply a write operation to a stored word
  function automatic logic [31:0] apply_op(input op_t op, input logic [31:0] word,
                                           input logic [31:0] data);
    logic [31:0] r;
    unique case (op)
      OP_REPL: r = data;
      OP_CLR:  r = word & ~data;
      OP_SET:  r = word | data;
      OP_TGL:  r = word ^ data;
      default: r = word;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gpio_port_register_block_top.sv =====
// gpio_port_register_block_top: register file of a gpio port with set/clear/toggle aliases
// depends on gprb_pkg for offsets, state and op types
//
// Usage:
//   Requests enter on the s_axis channel: tuser is the action (0 read, 1 write),
//   tdata holds offset, access size and write data. Each request gives exactly
//   one response on the m_axis channel: tdata is the read data (zero for writes
//   and refused requests), tuser is ok (0 for bad size or an access past the
//   end of the region).
//   The direction, output and input words of all groups live in one memory with
//   a registered read port. A request is decoded and its word read in the accept
//   cycle; in ST_RMW the block then modifies, writes back and loads the response
//   register once that register is free. No new request is taken until this
//   read-modify-write pass through the memory port is done.
//   The response register holds a finished response while the next request is
//   accepted; if the receiver stalls, the write-back waits until the response
//   register is free, and s_axis_tready stays low meanwhile.
//   Reset clears per-entry valid bits, so all words read as zero at once; no
//   clearing pass is needed.
`default_nettype none

module gpio_port_register_block_top
  import gprb_pkg::*;
#(
  parameter int GROUPS       = 4,
  parameter int GROUP_STRIDE = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [8:0] offset, [11:9] access_size, [43:12] write_data, [47:44] zero
  input  wire logic [47:0] s_axis_tdata,
  // [0] action
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] read_data
  output logic [31:0]      m_axis_tdata,
  // [0] ok
  output logic             m_axis_tuser
);

  localparam int DEPTH  = 4 * GROUPS;
  localparam int IDX_W  = $clog2(GROUPS) + 2;
  localparam int GOFF_W = $clog2(GROUP_STRIDE);

  // request fields
  logic [8:0]  in_offset;
  logic [2:0]  in_size;
  logic [31:0] in_data;

  assign in_offset = s_axis_tdata[8:0];
  assign in_size   = s_axis_tdata[11:9];
  assign in_data   = s_axis_tdata[43:12];

  // control
  state_t state, state_next;
  logic   accept;
  logic   out_free;
  logic   rmw_go;

  // decode of the incoming request
  logic [2:0]        grp;
  logic [8:0]        grp_base;
  logic [GOFF_W-1:0] goff;
  logic [GOFF_W-1:0] word_off;
  logic              size_ok;
  logic              range_ok;
  logic              in_grp;
  kind_t             kind;
  op_t               op;
  logic              hit;
  logic [IDX_W-1:0]  idx;

  // registered request
  logic             req_ok;
  logic             req_read;
  logic             req_hit;
  op_t              req_op;
  logic [1:0]       req_lane;
  logic [2:0]       req_size;
  logic [31:0]      req_data;
  logic [IDX_W-1:0] req_idx;

  // memory and its valid bits
  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [31:0]      rd_word;
  logic             rd_vld;

  // modify stage
  logic [31:0] word;
  logic [31:0] rd_value;
  logic [31:0] new_word;
  logic        do_write;

  // response register
  logic        out_valid;
  logic [31:0] out_data;
  logic        out_ok;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  // group select by comparing against each group base
  always_comb begin
    grp      = 3'd0;
    grp_base = 9'd0;
    for (int k = 1; k < 8; k++) begin
      if (32'(in_offset) >= 32'(k * GROUP_STRIDE)) begin
        grp      = 3'(k);
        grp_base = 9'(k * GROUP_STRIDE);
      end
    end
    goff     = GOFF_W'(in_offset - grp_base);
    word_off = {goff[GOFF_W-1:2], 2'b00};
  end

  // size, range and group checks
  always_comb begin
    size_ok  = (in_size != 3'd0) && (in_size <= 3'd4);
    range_ok = ({1'b0, in_offset} + {7'd0, in_size}) <= 10'(REGION_SIZE);
    in_grp   = 4'(grp) < 4'(GROUPS);
  end

  // word kind from the aligned offset
  always_comb begin
    if (word_off <= GOFF_W'(OFF_DIRTGL)) begin
      kind = KIND_DIR;
    end else if (word_off >= GOFF_W'(OFF_OUT) && word_off <= GOFF_W'(OFF_OUTTGL)) begin
      kind = KIND_OUT;
    end else if (word_off == GOFF_W'(OFF_IN)) begin
      kind = KIND_IN;
    end else begin
      kind = KIND_NONE;
    end
  end

  // write operation from the exact alias offset
  always_comb begin
    unique case (goff)
      GOFF_W'(OFF_DIR), GOFF_W'(OFF_OUT), GOFF_W'(OFF_IN): op = OP_REPL;
      GOFF_W'(OFF_DIRCLR), GOFF_W'(OFF_OUTCLR):              op = OP_CLR;
      GOFF_W'(OFF_DIRSET), GOFF_W'(OFF_OUTSET):              op = OP_SET;
      GOFF_W'(OFF_DIRTGL), GOFF_W'(OFF_OUTTGL):              op = OP_TGL;
      default:                                               op = OP_NONE;
    endcase
  end

  // memory index, pointed at entry zero when nothing is addressed
  always_comb begin
    hit = in_grp && (kind != KIND_NONE);
    idx = hit ? IDX_W'({grp, kind}) : '0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_RMW;
      ST_RMW:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rmw_go        = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RMW:  rmw_go = out_free;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the decoded request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_ok   <= size_ok && range_ok;
      req_read <= !s_axis_tuser;
      req_hit  <= hit;
      req_op   <= op;
      req_lane <= goff[1:0];
      req_size <= in_size;
      req_data <= in_data & size_mask(in_size);
      req_idx  <= idx;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= mem[idx];
      rd_vld  <= vld[idx];
    end
  end

  // modify the stored word
  always_comb begin
    word     = rd_vld ? rd_word : 32'd0;
    rd_value = (word >> {req_lane, 3'b000}) & size_mask(req_size);
    new_word = apply_op(req_op, word, req_data);
    do_write = rmw_go && req_ok && !req_read && req_hit && (req_op != OP_NONE);
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[req_idx] <= new_word;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (do_write) begin
      vld[req_idx] <= 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rmw_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rmw_go) begin
      out_ok   <= req_ok;
      out_data <= (req_ok && req_read && req_hit) ? rd_value : 32'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_ok;

  // an accepted request always moves to the modify state
  a_accept_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RMW))
    else $error("accepted request did not enter modify state");

  // a finished modify pass always presents a response
  a_rmw_resp: assert property (@(posedge clk) disable iff (rst)
    rmw_go |=> m_axis_tvalid)
    else $error("modify pass did not produce a response");

  // refused requests answer with zero data
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("refused request returned data");

  // writes answer with zero data
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (rmw_go && !req_read) |=> (m_axis_tdata == 32'd0))
    else $error("write request returned data");

  // the memory is only written during a modify pass
  a_write_in_rmw: assert property (@(posedge clk) disable iff (rst)
    do_write |-> (state == ST_RMW && out_free))
    else $error("memory written outside modify pass");

endmodule

`default_nettype wire

// ===== verif/gpio_port_register_block_top_tb.sv =====
// gpio_port_register_block_top_tb: self-checking bench for the gpio port register block
// depends on gprb_pkg and gpio_port_register_block_top; runs directed rows then random requests
// every response is checked against a behavioral copy of the port registers or a hand-written expectation
`default_nettype none

module gpio_port_register_block_top_tb
  import gprb_pkg::*;
();

  localparam int N_GROUPS      = 4;
  localparam int STRIDE        = 128;
  localparam int RANDOM_COUNT  = 1200;
  localparam int QUIET_TAIL    = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 8;
  localparam logic ACT_READ    = 1'b0;
  localparam logic ACT_WRITE   = 1'b1;
  localparam int ALIAS_OFFS[9] = '{OFF_DIR, OFF_DIRCLR, OFF_DIRSET, OFF_DIRTGL,
                                   OFF_OUT, OFF_OUTCLR, OFF_OUTSET, OFF_OUTTGL, OFF_IN};

  // one bus request, with an optional hand-written expectation
  typedef struct {
    logic        act;
    logic [8:0]  offset;
    logic [2:0]  size;
    logic [31:0] data;
    logic        known;
    logic [31:0] known_rd;
    logic        known_ok;
  } port_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        ok;
  } port_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  // shadow copy of the port words
  logic [31:0] dir_shadow [N_GROUPS];
  logic [31:0] out_shadow [N_GROUPS];
  logic [31:0] in_shadow  [N_GROUPS];

  port_req_t  directed_rows[$];
  port_resp_t pending_resp[$];
  port_resp_t want;
  logic       quiet_mode = 1'b0;
  int         err_count  = 0;
  int         resp_count = 0;
  int         read_count = 0;
  int         write_count = 0;
  int         refused_count = 0;
  int         stall_cycles = 0;

  gpio_port_register_block_top #(
    .GROUPS      (N_GROUPS),
    .GROUP_STRIDE(STRIDE)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bus access on the shadow registers: returns the response, applies writes
  function automatic port_resp_t access_port(input logic act, input logic [8:0] offset,
                                             input logic [2:0] size, input logic [31:0] data);
    port_resp_t  r;
    int          grp;
    int          goff;
    int          word_off;
    logic [31:0] mask;
    logic [31:0] word;
    r = '0;
    if (size == 3'd0 || size > 3'd4) return r;
    if (int'(offset) + int'(size) > REGION_SIZE) return r;
    grp = int'(offset) / STRIDE;
    goff = int'(offset) % STRIDE;
    mask = 32'hFFFF_FFFF >> (8 * (4 - int'(size)));
    r.ok = 1'b1;
    if (grp >= N_GROUPS) return r;
    if (act == ACT_READ) begin
      word_off = goff & ~3;
      if (word_off >= OFF_DIR && word_off <= OFF_DIRTGL) word = dir_shadow[grp];
      else if (word_off >= OFF_OUT && word_off <= OFF_OUTTGL) word = out_shadow[grp];
      else if (word_off == OFF_IN) word = in_shadow[grp];
      else word = '0;
      r.read_data = (word >> (8 * (goff & 3))) & mask;
    end else begin
      // sub-word data is zero-extended and only counts at an exact alias
      data = data & mask;
      case (goff)
        OFF_DIR:    dir_shadow[grp] = data;
        OFF_DIRCLR: dir_shadow[grp] &= ~data;
        OFF_DIRSET: dir_shadow[grp] |= data;
        OFF_DIRTGL: dir_shadow[grp] ^= data;
        OFF_OUT:    out_shadow[grp] = data;
        OFF_OUTCLR: out_shadow[grp] &= ~data;
        OFF_OUTSET: out_shadow[grp] |= data;
        OFF_OUTTGL: out_shadow[grp] ^= data;
        OFF_IN:     in_shadow[grp] = data;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH response %0d %s: got %h, want %h", resp_count, what, got, exp_val);
    err_count++;
  endtask

  task automatic add_row(input logic act, input int offset, input int size,
                         input logic [31:0] data);
    port_req_t r;
    r = '{act, offset[8:0], size[2:0], data, 1'b0, 32'h0, 1'b0};
    directed_rows.push_back(r);
  endtask

  task automatic add_known(input logic act, input int offset, input int size,
                           input logic [31:0] data, input logic [31:0] rd, input logic ok);
    port_req_t r;
    r = '{act, offset[8:0], size[2:0], data, 1'b1, rd, ok};
    directed_rows.push_back(r);
  endtask

  // random request, mostly well-formed accesses to alias offsets
  function automatic port_req_t random_request();
    port_req_t r;
    int        pick;
    int        sizes_bad[4];
    sizes_bad = '{0, 5, 6, 7};
    pick = $urandom_range(0, 99);
    r.act = 1'($urandom_range(0, 1));
    r.data = $urandom();
    r.known = 1'b0;
    r.known_rd = '0;
    r.known_ok = 1'b0;
    if (pick < 6) begin
      r.offset = 9'($urandom_range(0, 511));
      r.size = 3'(sizes_bad[$urandom_range(0, 3)]);
    end else if (pick < 14) begin
      r.offset = 9'($urandom_range(0, 511));
      r.size = 3'($urandom_range(1, 4));
    end else if (pick < 18) begin
      r.offset = 9'($urandom_range(REGION_SIZE - 4, REGION_SIZE - 1));
      r.size = 3'($urandom_range(1, 4));
    end else begin
      r.size = ($urandom_range(0, 1) == 0) ? 3'd4 : 3'($urandom_range(1, 4));
      r.offset = 9'($urandom_range(0, N_GROUPS - 1) * STRIDE +
                    ALIAS_OFFS[$urandom_range(0, 8)]);
      // reads at unaligned byte lanes
      if (r.act == ACT_READ && $urandom_range(0, 2) == 0) begin
        r.offset = r.offset + 9'($urandom_range(1, 3));
      end
    end
    return r;
  endfunction

  // response idling in bursts, none in the last part of the run
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (quiet_mode || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        n = quiet_mode ? 1 : $urandom_range(1, 15);
      end else begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 15);
      end
      repeat (n) @(posedge clk);
    end
  end

  // response check against the oldest pending request
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("with no pending request", m_axis_tdata, 32'h0);
      end else begin
        want = pending_resp.pop_front();
        if (m_axis_tdata !== want.read_data) report_mismatch("read_data", m_axis_tdata,
                                                             want.read_data);
        if (m_axis_tuser !== want.ok) report_mismatch("ok", 32'(m_axis_tuser), 32'(want.ok));
      end
      resp_count++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d responses pending", stall_cycles,
                 pending_resp.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // reset, directed rows, random requests, drain
  initial begin
    port_req_t  req;
    port_resp_t resp;
    int         total;
    int         gap;
    int         pause_at;

    for (int g = 0; g < N_GROUPS; g++) begin
      dir_shadow[g] = '0;
      out_shadow[g] = '0;
      in_shadow[g] = '0;
    end

    // after reset, refused sizes, the end of the region
    add_known(ACT_READ, OFF_DIR, 4, 32'h0, 32'h0, 1'b1);
    add_known(ACT_READ, 3 * STRIDE + 'h7C, 4, 32'h0, 32'h0, 1'b1);
    add_known(ACT_READ, OFF_OUT, 0, 32'h0, 32'h0, 1'b0);
    add_known(ACT_WRITE, OFF_DIR, 5, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_known(ACT_WRITE, OFF_IN, 7, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_known(ACT_READ, REGION_SIZE - 1, 2, 32'h0, 32'h0, 1'b0);
    add_known(ACT_READ, REGION_SIZE - 1, 1, 32'h0, 32'h0, 1'b1);
    // every alias of each word kind
    add_row(ACT_WRITE, OFF_DIR, 4, 32'hFFFF_FFFF);
    add_row(ACT_WRITE, OFF_DIRCLR, 4, 32'h0F0F_0F0F);
    add_row(ACT_WRITE, STRIDE + OFF_DIRSET, 4, 32'h1234_5678);
    add_row(ACT_WRITE, OFF_DIRTGL, 4, 32'hFFFF_0000);
    add_row(ACT_WRITE, 2 * STRIDE + OFF_OUT, 4, 32'hA5A5_A5A5);
    add_row(ACT_WRITE, 2 * STRIDE + OFF_OUTCLR, 4, 32'h0000_00FF);
    add_row(ACT_WRITE, 2 * STRIDE + OFF_OUTSET, 2, 32'hFFFF_0F0F);
    add_row(ACT_WRITE, 2 * STRIDE + OFF_OUTTGL, 1, 32'hFFFF_FF81);
    add_row(ACT_WRITE, 3 * STRIDE + OFF_IN, 4, 32'hDEAD_BEEF);
    // byte lanes, lanes past the word, sub-word writes off the alias
    add_row(ACT_READ, 3 * STRIDE + OFF_IN + 1, 2, 32'h0);
    add_row(ACT_READ, 3 * STRIDE + OFF_IN + 3, 4, 32'h0);
    add_row(ACT_READ, OFF_DIRCLR + 1, 3, 32'h0);
    add_row(ACT_WRITE, 2 * STRIDE + OFF_OUT + 1, 1, 32'hFFFF_FFFF);
    add_row(ACT_READ, 2 * STRIDE + OFF_OUT, 4, 32'h0);
    add_row(ACT_READ, STRIDE + OFF_DIRTGL + 2, 2, 32'h0);
    // undefined offsets
    add_row(ACT_WRITE, 'h40, 4, 32'hFFFF_FFFF);
    add_row(ACT_READ, 'h40, 4, 32'h0);
    add_row(ACT_READ, OFF_IN + 4, 4, 32'h0);
    add_row(ACT_WRITE, REGION_SIZE - 4, 4, 32'hFFFF_FFFF);

    total = directed_rows.size() + RANDOM_COUNT;
    pause_at = directed_rows.size() + RANDOM_COUNT / 2;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < total; i++) begin
      req = (i < directed_rows.size()) ? directed_rows[i] : random_request();
      if (i >= total - QUIET_TAIL) quiet_mode = 1'b1;

      // sender gaps; once, hold off until every response is back
      gap = (!quiet_mode && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      if (i == pause_at && gap == 0) gap = 1;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (i == pause_at) begin
          while (pending_resp.size() != 0) @(posedge clk);
        end
      end

      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= req.act;
      s_axis_tdata <= {4'b0, req.data, req.size, req.offset};
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);

      // request accepted at this edge
      resp = access_port(req.act, req.offset, req.size, req.data);
      if (req.known) resp = '{req.known_rd, req.known_ok};
      pending_resp.push_back(resp);
      if (!resp.ok) refused_count++;
      else if (req.act == ACT_READ) read_count++;
      else write_count++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests: %0d reads, %0d writes, %0d refused", total,
             read_count, write_count, refused_count);
    $display("%0d responses checked, %0d mismatches", resp_count, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
